FILE: rtl/core/nvq_pkg.sv
`default_nettype none

package nvq_pkg;

	localparam int PIX_W  = 8;
	localparam int OFF_W  = 9;
	localparam int COEF_W = 19;
	localparam int PROD_W = OFF_W + COEF_W;
	localparam int SUM_W  = PROD_W + 2;
	localparam int FRAC_W = 16;
	localparam int LANES  = 4;

	localparam logic signed [COEF_W-1:0] COEF_Y  = 19'sd76309;
	localparam logic signed [COEF_W-1:0] COEF_BU = 19'sd132201;
	localparam logic signed [COEF_W-1:0] COEF_GU = 19'sd25675;
	localparam logic signed [COEF_W-1:0] COEF_GV = 19'sd53279;
	localparam logic signed [COEF_W-1:0] COEF_RV = 19'sd104597;

	localparam logic signed [OFF_W-1:0] LUMA_OFS   = 9'sd16;
	localparam logic signed [OFF_W-1:0] CHROMA_OFS = 9'sd128;

	typedef struct packed {
		logic [PIX_W-1:0] luma_top_left;
		logic [PIX_W-1:0] luma_top_right;
		logic [PIX_W-1:0] luma_bottom_left;
		logic [PIX_W-1:0] luma_bottom_right;
		logic [PIX_W-1:0] chroma_blue;
		logic [PIX_W-1:0] chroma_red;
	} quad_t;

	typedef struct packed {
		logic [PIX_W-1:0] blue_top_left;
		logic [PIX_W-1:0] green_top_left;
		logic [PIX_W-1:0] red_top_left;
		logic [PIX_W-1:0] blue_top_right;
		logic [PIX_W-1:0] green_top_right;
		logic [PIX_W-1:0] red_top_right;
		logic [PIX_W-1:0] blue_bottom_left;
		logic [PIX_W-1:0] green_bottom_left;
		logic [PIX_W-1:0] red_bottom_left;
		logic [PIX_W-1:0] blue_bottom_right;
		logic [PIX_W-1:0] green_bottom_right;
		logic [PIX_W-1:0] red_bottom_right;
	} rgb_quad_t;

	// one pixel as it leaves a lane
	typedef struct packed {
		logic [PIX_W-1:0] blue;
		logic [PIX_W-1:0] green;
		logic [PIX_W-1:0] red;
	} bgr_t;

	// shared chroma products, one set per quad
	typedef struct packed {
		logic signed [PROD_W-1:0] blue_cb;
		logic signed [PROD_W-1:0] green_cb;
		logic signed [PROD_W-1:0] green_cr;
		logic signed [PROD_W-1:0] red_cr;
	} chroma_term_t;

	// remove the offset from an 8-bit sample
	function automatic logic signed [OFF_W-1:0] unbias(
		input logic [PIX_W-1:0] s,
		input logic signed [OFF_W-1:0] ofs
	);
		unbias = $signed({1'b0, s}) - ofs;
	endfunction

	// floor shift by the fraction width, then clamp to 0..255
	function automatic logic [PIX_W-1:0] to_byte(input logic signed [SUM_W-1:0] s);
		logic [PIX_W-1:0] r;
		if (s[SUM_W-1]) begin
			r = '0;
		end else if (|s[SUM_W-2:FRAC_W+PIX_W]) begin
			r = '1;
		end else begin
			r = s[FRAC_W+PIX_W-1:FRAC_W];
		end
		to_byte = r;
	endfunction

endpackage

`default_nettype wire

FILE: rtl/core/nvq_chroma.sv
`default_nettype none

module nvq_chroma (
	input  wire logic                 clk,
	input  wire logic                 load,
	input  wire logic [7:0]           chroma_blue,
	input  wire logic [7:0]           chroma_red,
	output nvq_pkg::chroma_term_t     terms
);
	import nvq_pkg::*;

	logic signed [OFF_W-1:0] cb;
	logic signed [OFF_W-1:0] cr;
	chroma_term_t terms_s1;

	assign cb = unbias(chroma_blue, CHROMA_OFS);
	assign cr = unbias(chroma_red, CHROMA_OFS);

	always_ff @(posedge clk) begin
		if (load) begin
			terms_s1.blue_cb  <= cb * COEF_BU;
			terms_s1.green_cb <= cb * COEF_GU;
			terms_s1.green_cr <= cr * COEF_GV;
			terms_s1.red_cr   <= cr * COEF_RV;
		end
	end

	assign terms = terms_s1;

endmodule

`default_nettype wire

FILE: rtl/core/nvq_lane.sv
`default_nettype none

module nvq_lane (
	input  wire logic                 clk,
	input  wire logic                 load,
	input  wire logic [7:0]           luma,
	input  wire nvq_pkg::chroma_term_t terms,
	output nvq_pkg::bgr_t             pix
);
	import nvq_pkg::*;

	logic signed [OFF_W-1:0]  y_off;
	logic signed [PROD_W-1:0] lum_s1;
	logic signed [SUM_W-1:0]  blue_sum;
	logic signed [SUM_W-1:0]  green_sum;
	logic signed [SUM_W-1:0]  red_sum;

	assign y_off = unbias(luma, LUMA_OFS);

	// scaled luma, lined up with the shared chroma products
	always_ff @(posedge clk) begin
		if (load) begin
			lum_s1 <= y_off * COEF_Y;
		end
	end

	always_comb begin
		blue_sum  = SUM_W'(lum_s1) + SUM_W'(terms.blue_cb);
		green_sum = SUM_W'(lum_s1) - SUM_W'(terms.green_cb) - SUM_W'(terms.green_cr);
		red_sum   = SUM_W'(lum_s1) + SUM_W'(terms.red_cr);
		pix.blue  = to_byte(blue_sum);
		pix.green = to_byte(green_sum);
		pix.red   = to_byte(red_sum);
	end

endmodule

`default_nettype wire

FILE: rtl/core/nv12_quad_to_rgb.sv
// channel | valid      | ready      | word
// --------+------------+------------+-----------------------------------
// in      | quad_valid | quad_ready | quad: four luma, shared cb/cr
// out     | pix_valid  | pix_ready  | pix: blue/green/red of four pixels
//
// an accepted quad goes through stage 1, then stage 2, to its pixel word; one quad
// per clock sustained while pix_ready holds, set by the two-stage multiply/sum pipeline
// stage 1 holds the luma products (one per lane) and the shared chroma products
// stage 2 is the merge register that packs the four lanes into one word
// arst_n clears only the stage valid flags
// a stalled output holds stage 2; stage 1 still fills behind it, so quad_ready
// drops only when both stages hold a word

`default_nettype none

module nv12_quad_to_rgb (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              quad_valid,
	output logic                   quad_ready,
	input  wire nvq_pkg::quad_t    quad,
	output logic                   pix_valid,
	input  wire logic              pix_ready,
	output nvq_pkg::rgb_quad_t     pix
);
	import nvq_pkg::*;

	logic         valid_s1;
	logic         valid_s2;
	logic         adv1;
	logic         adv2;
	logic         load1;
	logic         load2;
	chroma_term_t terms;
	logic [PIX_W-1:0] luma [LANES];
	bgr_t         lane_pix [LANES];
	rgb_quad_t    pix_s2;

	// pipeline advance: a stage moves when the one after it has room
	assign adv2       = !valid_s2 || pix_ready;
	assign adv1       = !valid_s1 || adv2;
	assign quad_ready = adv1;
	assign load1      = quad_valid && adv1;
	assign load2      = valid_s1 && adv2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (adv1) begin
				valid_s1 <= quad_valid;
			end
			if (adv2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	// lane order: upper left, upper right, lower left, lower right
	assign luma[0] = quad.luma_top_left;
	assign luma[1] = quad.luma_top_right;
	assign luma[2] = quad.luma_bottom_left;
	assign luma[3] = quad.luma_bottom_right;

	nvq_chroma u_chroma (
		.clk         (clk),
		.load        (load1),
		.chroma_blue (quad.chroma_blue),
		.chroma_red  (quad.chroma_red),
		.terms       (terms)
	);

	for (genvar i = 0; i < LANES; i++) begin : g_lane
		nvq_lane u_lane (
			.clk   (clk),
			.load  (load1),
			.luma  (luma[i]),
			.terms (terms),
			.pix   (lane_pix[i])
		);
	end

	// merge the lanes into the output word
	always_ff @(posedge clk) begin
		if (load2) begin
			pix_s2.blue_top_left      <= lane_pix[0].blue;
			pix_s2.green_top_left     <= lane_pix[0].green;
			pix_s2.red_top_left       <= lane_pix[0].red;
			pix_s2.blue_top_right     <= lane_pix[1].blue;
			pix_s2.green_top_right    <= lane_pix[1].green;
			pix_s2.red_top_right      <= lane_pix[1].red;
			pix_s2.blue_bottom_left   <= lane_pix[2].blue;
			pix_s2.green_bottom_left  <= lane_pix[2].green;
			pix_s2.red_bottom_left    <= lane_pix[2].red;
			pix_s2.blue_bottom_right  <= lane_pix[3].blue;
			pix_s2.green_bottom_right <= lane_pix[3].green;
			pix_s2.red_bottom_right   <= lane_pix[3].red;
		end
	end

	assign pix_valid = valid_s2;
	assign pix       = pix_s2;

endmodule

`default_nettype wire

FILE: rtl/core/nvq_checker.sv
`default_nettype none

module nvq_checker (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              quad_valid,
	input  wire logic              quad_ready,
	input  wire nvq_pkg::quad_t    quad,
	input  wire logic              pix_valid,
	input  wire logic              pix_ready,
	input  wire nvq_pkg::rgb_quad_t pix
);
	import nvq_pkg::*;

	// a stalled word stays put
	a_pix_hold: assert property (@(posedge clk) disable iff (!arst_n)
		pix_valid && !pix_ready |=> pix_valid && $stable(pix))
		else $error("pix word changed while stalled");

	// an accepted quad is followed by pix_valid once it has passed both stages
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		quad_valid && quad_ready |-> ##2 pix_valid)
		else $error("pix word missing after accepted quad");

	// with the output empty there is always room for a quad
	a_room: assert property (@(posedge clk) disable iff (!arst_n)
		!pix_valid |-> quad_ready)
		else $error("quad_ready low with empty output");

	// back-pressure only when the output is stalled
	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!quad_ready |-> pix_valid && !pix_ready)
		else $error("quad_ready low without output stall");

endmodule

bind nv12_quad_to_rgb nvq_checker u_nvq_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.quad_valid (quad_valid),
	.quad_ready (quad_ready),
	.quad       (quad),
	.pix_valid  (pix_valid),
	.pix_ready  (pix_ready),
	.pix        (pix)
);

`default_nettype wire
